// File: src/mlfd_pkg.sv
`default_nettype none

package mlfd_pkg;

  localparam int HEADER_BYTES    = 32;
  localparam int MAX_FRAME_BYTES = 4096;

  // header field positions
  localparam int MAGIC_AT = 0;
  localparam int VER_AT   = 4;
  localparam int LEN_AT   = 24;

  localparam int HDR_AW  = $clog2(HEADER_BYTES);
  localparam int TOTAL_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CAP_W   = 13;
  localparam int OFFS_W  = 12;

  localparam logic [31:0] MAX_PLEN = 32'(MAX_FRAME_BYTES - HEADER_BYTES);

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_MAGIC    = 3'd1,
    STAT_VERSION  = 3'd2,
    STAT_LENGTH   = 3'd3,
    STAT_CAPACITY = 3'd4,
    STAT_ABORT    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CFG_MAGIC    = 2'd0,
    CFG_VERSION  = 2'd1,
    CFG_CAPACITY = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_COLLECT,
    S_CHECK,
    S_REPLAY,
    S_PAYLOAD
  } state_t;

  typedef struct packed {
    logic              en;
    logic [HDR_AW-1:0] idx;
    logic [7:0]        data;
  } hdr_wr_t;

  typedef struct packed {
    status_t            status;
    logic [TOTAL_W-1:0] total;
  } chk_res_t;

endpackage

`default_nettype wire

// File: src/magic_length_frame_deframer.sv
`default_nettype none

// Length-prefixed frame deframer. Header bytes are written into a 32-entry
// header RAM at one word per cycle, unless a stalled output word holds the
// input, and produce no output until the header is complete; the cycle after
// the last header byte the magic, version, payload length and capacity checks
// resolve (no word is taken in that cycle). A failed check emits one error
// word. A good header is replayed from the RAM, then payload words pass
// through with byte_offset and frame_end, both at one word per cycle unless
// the output stalls; no input is taken until the replay ends. A stream reset
// command emits an aborted word when a frame was open. Configuration writes are
// always ready and take effect at once; write them only while the block is idle.
module magic_length_frame_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [7:0]  in_byte,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic [11:0]      out_byte_offset,
  output logic             out_frame_end,
  output logic             out_run_end,
  output logic [2:0]       out_status,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int AW = mlfd_pkg::HDR_AW;
  localparam int TW = mlfd_pkg::TOTAL_W;

  logic [31:0]                magic_word_r;
  logic [15:0]                protocol_version_r;
  logic [mlfd_pkg::CAP_W-1:0] frame_capacity_r;

  mlfd_pkg::state_t state_r, state_nxt;
  logic [TW-1:0]    byte_count_r, byte_count_nxt;
  logic [TW-1:0]    frame_total_r, frame_total_nxt;
  logic [AW-1:0]    rd_idx_r, rd_idx_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_from_ram_r, out_from_ram_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic [11:0]      out_offset_r, out_offset_nxt;
  logic             out_frame_end_r, out_frame_end_nxt;
  logic             out_run_end_r, out_run_end_nxt;
  mlfd_pkg::status_t out_status_r, out_status_nxt;

  mlfd_pkg::hdr_wr_t  hdr_wr;
  mlfd_pkg::chk_res_t chk;
  logic               ram_re;
  logic [7:0]         ram_rdata;
  logic               in_take;
  logic               out_free;
  logic [TW-1:0]      count_inc;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_word_r       <= '0;
      protocol_version_r <= '0;
      frame_capacity_r   <= mlfd_pkg::CAP_W'(4096);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mlfd_pkg::CFG_MAGIC:    magic_word_r       <= cfg_data;
        mlfd_pkg::CFG_VERSION:  protocol_version_r <= cfg_data[15:0];
        mlfd_pkg::CFG_CAPACITY: frame_capacity_r   <= cfg_data[mlfd_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  mlfd_ram #(
    .WIDTH(8),
    .DEPTH(mlfd_pkg::HEADER_BYTES)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (hdr_wr.en),
    .waddr (hdr_wr.idx),
    .wdata (hdr_wr.data),
    .re    (ram_re),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  mlfd_hdr_chk u_hdr_chk (
    .clk              (clk),
    .hdr_wr           (hdr_wr),
    .magic_word       (magic_word_r),
    .protocol_version (protocol_version_r),
    .frame_capacity   (frame_capacity_r),
    .res              (chk)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !(((state_r == mlfd_pkg::S_COLLECT) || (state_r == mlfd_pkg::S_PAYLOAD))
                       && out_free);
  assign in_take   = in_valid && !in_stall;
  assign count_inc = byte_count_r + TW'(1);

  always_comb begin
    state_nxt         = state_r;
    byte_count_nxt    = byte_count_r;
    frame_total_nxt   = frame_total_r;
    rd_idx_nxt        = rd_idx_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_from_ram_nxt  = out_from_ram_r;
    out_byte_nxt      = out_byte_r;
    out_offset_nxt    = out_offset_r;
    out_frame_end_nxt = out_frame_end_r;
    out_run_end_nxt   = out_run_end_r;
    out_status_nxt    = out_status_r;
    hdr_wr.en         = 1'b0;
    hdr_wr.idx        = byte_count_r[AW-1:0];
    hdr_wr.data       = in_byte;
    ram_re            = 1'b0;

    case (state_r)
      mlfd_pkg::S_COLLECT: begin
        if (in_take) begin
          if (in_command) begin
            if (byte_count_r != '0) begin
              out_valid_nxt     = 1'b1;
              out_from_ram_nxt  = 1'b0;
              out_byte_nxt      = '0;
              out_offset_nxt    = '0;
              out_frame_end_nxt = 1'b0;
              out_run_end_nxt   = 1'b1;
              out_status_nxt    = mlfd_pkg::STAT_ABORT;
            end
            byte_count_nxt = '0;
          end else begin
            hdr_wr.en = 1'b1;
            if (byte_count_r == TW'(mlfd_pkg::HEADER_BYTES - 1)) begin
              state_nxt      = mlfd_pkg::S_CHECK;
              byte_count_nxt = '0;
            end else begin
              byte_count_nxt = count_inc;
            end
          end
        end
      end

      mlfd_pkg::S_CHECK: begin
        if (chk.status != mlfd_pkg::STAT_OK) begin
          out_valid_nxt     = 1'b1;
          out_from_ram_nxt  = 1'b0;
          out_byte_nxt      = '0;
          out_offset_nxt    = '0;
          out_frame_end_nxt = 1'b0;
          out_run_end_nxt   = 1'b1;
          out_status_nxt    = chk.status;
          state_nxt         = mlfd_pkg::S_COLLECT;
        end else begin
          frame_total_nxt = chk.total;
          rd_idx_nxt      = '0;
          state_nxt       = mlfd_pkg::S_REPLAY;
        end
      end

      mlfd_pkg::S_REPLAY: begin
        if (out_free) begin
          ram_re            = 1'b1;
          out_valid_nxt     = 1'b1;
          out_from_ram_nxt  = 1'b1;
          out_offset_nxt    = 12'(rd_idx_r);
          out_status_nxt    = mlfd_pkg::STAT_OK;
          out_run_end_nxt   = 1'b0;
          out_frame_end_nxt = 1'b0;
          rd_idx_nxt        = rd_idx_r + AW'(1);
          if (rd_idx_r == AW'(mlfd_pkg::HEADER_BYTES - 1)) begin
            out_run_end_nxt = 1'b1;
            if (frame_total_r == TW'(mlfd_pkg::HEADER_BYTES)) begin
              out_frame_end_nxt = 1'b1;
              byte_count_nxt    = '0;
              state_nxt         = mlfd_pkg::S_COLLECT;
            end else begin
              byte_count_nxt = TW'(mlfd_pkg::HEADER_BYTES);
              state_nxt      = mlfd_pkg::S_PAYLOAD;
            end
          end
        end
      end

      mlfd_pkg::S_PAYLOAD: begin
        if (in_take) begin
          out_valid_nxt    = 1'b1;
          out_from_ram_nxt = 1'b0;
          out_run_end_nxt  = 1'b1;
          if (in_command) begin
            out_byte_nxt      = '0;
            out_offset_nxt    = '0;
            out_frame_end_nxt = 1'b0;
            out_status_nxt    = mlfd_pkg::STAT_ABORT;
            byte_count_nxt    = '0;
            state_nxt         = mlfd_pkg::S_COLLECT;
          end else begin
            out_byte_nxt   = in_byte;
            out_offset_nxt = byte_count_r[11:0];
            out_status_nxt = mlfd_pkg::STAT_OK;
            if (count_inc >= frame_total_r) begin
              out_frame_end_nxt = 1'b1;
              byte_count_nxt    = '0;
              state_nxt         = mlfd_pkg::S_COLLECT;
            end else begin
              out_frame_end_nxt = 1'b0;
              byte_count_nxt    = count_inc;
            end
          end
        end
      end

      default: begin
        state_nxt      = mlfd_pkg::S_COLLECT;
        byte_count_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= mlfd_pkg::S_COLLECT;
      byte_count_r  <= '0;
      frame_total_r <= '0;
      rd_idx_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      byte_count_r  <= byte_count_nxt;
      frame_total_r <= frame_total_nxt;
      rd_idx_r      <= rd_idx_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_from_ram_r  <= out_from_ram_nxt;
    out_byte_r      <= out_byte_nxt;
    out_offset_r    <= out_offset_nxt;
    out_frame_end_r <= out_frame_end_nxt;
    out_run_end_r   <= out_run_end_nxt;
    out_status_r    <= out_status_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_from_ram_r ? ram_rdata : out_byte_r;
  assign out_byte_offset = out_offset_r;
  assign out_frame_end   = out_frame_end_r;
  assign out_run_end     = out_run_end_r;
  assign out_status      = out_status_r;

  a_take_only_when_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> (state_r == mlfd_pkg::S_COLLECT) || (state_r == mlfd_pkg::S_PAYLOAD))
    else $error("input word taken during check or replay");

  a_check_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mlfd_pkg::S_CHECK |-> !out_valid_r)
    else $error("output slot busy while header check resolves");

  a_error_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != 3'(mlfd_pkg::STAT_OK) |->
      out_byte == 8'd0 && out_byte_offset == 12'd0 && !out_frame_end && out_run_end)
    else $error("error word carries frame data");

  a_payload_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mlfd_pkg::S_PAYLOAD |->
      byte_count_r >= TW'(mlfd_pkg::HEADER_BYTES) && byte_count_r < frame_total_r)
    else $error("payload byte count outside frame");

endmodule

`default_nettype wire

// File: src/mlfd_ram.sv
`default_nettype none

module mlfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/mlfd_hdr_chk.sv
`default_nettype none

module mlfd_hdr_chk (
  input  wire logic                          clk,
  input  wire mlfd_pkg::hdr_wr_t             hdr_wr,
  input  wire logic [31:0]                   magic_word,
  input  wire logic [15:0]                   protocol_version,
  input  wire logic [mlfd_pkg::CAP_W-1:0]    frame_capacity,
  output mlfd_pkg::chk_res_t                 res
);

  logic [31:0] magic_r;
  logic [15:0] ver_r;
  logic [31:0] plen_r;
  logic [31:0] total_ext;

  // snoop header writes and keep the fields that the check needs
  always_ff @(posedge clk) begin
    if (hdr_wr.en) begin
      for (int k = 0; k < 4; k++) begin
        if (hdr_wr.idx == mlfd_pkg::HDR_AW'(mlfd_pkg::MAGIC_AT + k)) begin
          magic_r[8*k +: 8] <= hdr_wr.data;
        end
        if (hdr_wr.idx == mlfd_pkg::HDR_AW'(mlfd_pkg::LEN_AT + k)) begin
          plen_r[8*k +: 8] <= hdr_wr.data;
        end
      end
      for (int k = 0; k < 2; k++) begin
        if (hdr_wr.idx == mlfd_pkg::HDR_AW'(mlfd_pkg::VER_AT + k)) begin
          ver_r[8*k +: 8] <= hdr_wr.data;
        end
      end
    end
  end

  assign total_ext = 32'(mlfd_pkg::HEADER_BYTES) + plen_r;

  always_comb begin
    res.total = total_ext[mlfd_pkg::TOTAL_W-1:0];
    if (magic_r != magic_word) begin
      res.status = mlfd_pkg::STAT_MAGIC;
    end else if (ver_r != protocol_version) begin
      res.status = mlfd_pkg::STAT_VERSION;
    end else if (plen_r > mlfd_pkg::MAX_PLEN) begin
      res.status = mlfd_pkg::STAT_LENGTH;
    end else if (total_ext > 32'(frame_capacity)) begin
      res.status = mlfd_pkg::STAT_CAPACITY;
    end else begin
      res.status = mlfd_pkg::STAT_OK;
    end
  end

endmodule

`default_nettype wire

// File: tb/deframer_checker.sv
package deframer_tb_pkg;

  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

endpackage

module deframer_checker (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_byte,

  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic [11:0] out_byte_offset,
  input  logic        out_frame_end,
  input  logic        out_run_end,
  input  logic [2:0]  out_status,

  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,

  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import mlfd_pkg::*;
  import deframer_tb_pkg::*;

  localparam int PRINT_LIMIT = 200;

  typedef struct packed {
    logic [7:0]        data;
    logic [OFFS_W-1:0] offset;
    logic              frame_end;
    logic              run_end;
    status_t           status;
  } deframe_word_t;

  deframe_word_t      expected_words [$];

  logic [31:0]        exp_magic;
  logic [15:0]        exp_version;
  logic [CAP_W-1:0]   cap_limit;

  logic [7:0]         hdr_store [HEADER_BYTES];
  logic [TOTAL_W-1:0] collected;
  logic [TOTAL_W-1:0] frame_bytes;
  logic               in_body;

  task automatic clear_parser();
    collected   = '0;
    frame_bytes = '0;
    in_body     = 1'b0;
  endtask

  task automatic queue_word(input logic [7:0] data, input logic [OFFS_W-1:0] offs,
                            input logic fend, input logic rend, input status_t st);
    deframe_word_t w;
    w.data      = data;
    w.offset    = offs;
    w.frame_end = fend;
    w.run_end   = rend;
    w.status    = st;
    expected_words.push_back(w);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want, input logic [OFFS_W-1:0] offs);
    if (fail_count < PRINT_LIMIT)
      $display("deframer mismatch on %s: got %0h, expected %0h (offset %0d)",
               field, got, want, offs);
    fail_count++;
  endtask

  task automatic predict_deframe(input logic cmd, input logic [7:0] b);
    logic [31:0] rx_magic;
    logic [31:0] plen;
    logic [31:0] total;
    logic [15:0] rx_version;
    status_t     verdict;
    logic        last_byte;
    logic        was_open;
    int          i;
    if (cmd == CMD_FLUSH) begin
      was_open = in_body || (collected != '0);
      clear_parser();
      if (was_open) queue_word(8'h00, '0, 1'b0, 1'b1, STAT_ABORT);
      return;
    end
    if (in_body) begin
      last_byte = ({1'b0, collected} + 1) >= {1'b0, frame_bytes};
      queue_word(b, collected[OFFS_W-1:0], last_byte, 1'b1, STAT_OK);
      if (last_byte) clear_parser();
      else collected = collected + 1'b1;
      return;
    end
    // restart if the count ever ran past the header while collecting
    if (collected >= TOTAL_W'(HEADER_BYTES)) clear_parser();
    hdr_store[collected[HDR_AW-1:0]] = b;
    collected = collected + 1'b1;
    if (collected < TOTAL_W'(HEADER_BYTES)) return;

    rx_magic   = {hdr_store[MAGIC_AT+3], hdr_store[MAGIC_AT+2],
                  hdr_store[MAGIC_AT+1], hdr_store[MAGIC_AT]};
    rx_version = {hdr_store[VER_AT+1], hdr_store[VER_AT]};
    plen       = {hdr_store[LEN_AT+3], hdr_store[LEN_AT+2],
                  hdr_store[LEN_AT+1], hdr_store[LEN_AT]};
    total      = 32'(HEADER_BYTES) + plen;
    if (rx_magic != exp_magic) verdict = STAT_MAGIC;
    else if (rx_version != exp_version) verdict = STAT_VERSION;
    else if (plen > MAX_PLEN) verdict = STAT_LENGTH;
    else if (total > 32'(cap_limit)) verdict = STAT_CAPACITY;
    else verdict = STAT_OK;

    if (verdict != STAT_OK) begin
      clear_parser();
      queue_word(8'h00, '0, 1'b0, 1'b1, verdict);
      return;
    end
    // replay the header; an empty payload ends the frame on its last byte
    for (i = 0; i < HEADER_BYTES; i++) begin
      queue_word(hdr_store[i], OFFS_W'(i),
                 (i == HEADER_BYTES - 1) && (total == 32'(HEADER_BYTES)),
                 i == HEADER_BYTES - 1, STAT_OK);
    end
    if (total == 32'(HEADER_BYTES)) begin
      clear_parser();
    end else begin
      in_body     = 1'b1;
      frame_bytes = total[TOTAL_W-1:0];
      collected   = TOTAL_W'(HEADER_BYTES);
    end
  endtask

  task automatic check_word();
    deframe_word_t want;
    if (expected_words.size() == 0) begin
      report_mismatch("word with none pending, byte", 32'(out_byte), 32'h0, out_byte_offset);
      return;
    end
    want = expected_words.pop_front();
    if (out_byte !== want.data)
      report_mismatch("out_byte", 32'(out_byte), 32'(want.data), want.offset);
    if (out_byte_offset !== want.offset)
      report_mismatch("byte_offset", 32'(out_byte_offset), 32'(want.offset), want.offset);
    if (out_frame_end !== want.frame_end)
      report_mismatch("frame_end", 32'(out_frame_end), 32'(want.frame_end), want.offset);
    if (out_run_end !== want.run_end)
      report_mismatch("run_end", 32'(out_run_end), 32'(want.run_end), want.offset);
    if (out_status !== want.status)
      report_mismatch("status", 32'(out_status), 32'(want.status), want.offset);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      exp_magic   = '0;
      exp_version = '0;
      cap_limit   = CAP_W'(MAX_FRAME_BYTES);
      clear_parser();
      expected_words.delete();
      fail_count  = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAGIC:    exp_magic   = cfg_data;
          CFG_VERSION:  exp_version = cfg_data[15:0];
          CFG_CAPACITY: cap_limit   = cfg_data[CAP_W-1:0];
          default: ;
        endcase
      end
      // predict first, then check any output word taken in the same cycle
      if (in_valid && !in_stall) predict_deframe(in_command, in_byte);
      if (out_valid && !out_stall) check_word();
    end
    pending = expected_words.size();
  end

endmodule

// File: tb/magic_length_frame_deframer_test.sv
module magic_length_frame_deframer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mlfd_pkg::*;
  import deframer_tb_pkg::*;

  localparam int         RESET_CYCLES   = 12;
  localparam int         HOLD_CYCLES    = 200;
  localparam int         SETTLE_CYCLES  = 40;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         PHASE_ITEMS    = 20;
  localparam int         PHASES         = 2;
  localparam logic [1:0] CFG_UNUSED     = 2'd3;

  typedef enum int {
    FR_GOOD,
    FR_BAD_MAGIC,
    FR_BAD_VERSION,
    FR_BAD_LENGTH,
    FR_OVER_CAP,
    FR_CUT_HEADER,
    FR_CUT_PAYLOAD
  } frame_kind_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_command;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic [11:0] out_byte_offset;
  logic        out_frame_end;
  logic        out_run_end;
  logic [2:0]  out_status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  int          fail_count;
  int          pending_words;
  int          items_sent;
  bit          calm;
  bit          hold_req;
  logic [31:0] cur_magic;
  logic [15:0] cur_version;
  int          cur_cap;

  magic_length_frame_deframer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_byte_offset (out_byte_offset),
    .out_frame_end   (out_frame_end),
    .out_run_end     (out_run_end),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  deframer_checker frame_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_byte_offset (out_byte_offset),
    .out_frame_end   (out_frame_end),
    .out_run_end     (out_run_end),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending_words)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // downstream: random stalls, or one long hold-off when asked
  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall <= !calm && ($urandom_range(99) < 12);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("** magic_length_frame_deframer: FAILED **");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_word(input logic cmd, input logic [7:0] b);
    while (!calm && ($urandom_range(99) < 12)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_byte    <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    case (idx)
      CFG_MAGIC:    cur_magic   = data;
      CFG_VERSION:  cur_version = data[15:0];
      CFG_CAPACITY: cur_cap     = int'(data[CAP_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [31:0] magic, input logic [31:0] ver,
                                input logic [31:0] cap, input bit poke_unused);
    write_reg(CFG_MAGIC, magic);
    write_reg(CFG_VERSION, ver);
    write_reg(CFG_CAPACITY, cap);
    if (poke_unused) write_reg(CFG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // payload length that fits the current capacity, mostly short
  function automatic logic [31:0] fit_len();
    int room;
    room = cur_cap - HEADER_BYTES;
    if (room <= 0) return 32'd0;
    if (room > int'(MAX_PLEN)) room = int'(MAX_PLEN);
    if ($urandom_range(9) == 0) return $urandom_range(room < 40 ? room : 40);
    return $urandom_range(room < 12 ? room : 12);
  endfunction

  task automatic send_frame(input frame_kind_t kind, input int want_len);
    logic [7:0]  hdr [HEADER_BYTES];
    logic [31:0] magic;
    logic [31:0] plen;
    logic [15:0] ver;
    int          cut;
    int          body;
    int          i;
    magic = cur_magic;
    ver   = cur_version;
    plen  = fit_len();
    case (kind)
      FR_BAD_MAGIC:   magic = magic ^ (32'd1 << $urandom_range(31));
      FR_BAD_VERSION: ver = ver ^ (16'd1 << $urandom_range(15));
      FR_BAD_LENGTH: begin
        case ($urandom_range(2))
          0:       plen = MAX_PLEN + 1;
          1:       plen = '1;
          default: plen = $urandom | 32'h0001_0000;
        endcase
      end
      FR_OVER_CAP: begin
        if (cur_cap < HEADER_BYTES) plen = $urandom_range(8);
        else if (cur_cap < MAX_FRAME_BYTES)
          plen = $urandom_range(MAX_PLEN, cur_cap - HEADER_BYTES + 1);
        else plen = MAX_PLEN + 1;
      end
      default: ;
    endcase
    if (want_len >= 0) plen = want_len;

    for (i = 0; i < HEADER_BYTES; i++) hdr[i] = 8'($urandom);
    {hdr[MAGIC_AT+3], hdr[MAGIC_AT+2], hdr[MAGIC_AT+1], hdr[MAGIC_AT]} = magic;
    {hdr[VER_AT+1], hdr[VER_AT]} = ver;
    {hdr[LEN_AT+3], hdr[LEN_AT+2], hdr[LEN_AT+1], hdr[LEN_AT]} = plen;

    cut = (kind == FR_CUT_HEADER) ? $urandom_range(HEADER_BYTES - 1, 1) : HEADER_BYTES;
    for (i = 0; i < cut; i++) send_word(CMD_DATA, hdr[i]);
    if (kind == FR_CUT_HEADER) begin
      send_word(CMD_FLUSH, 8'($urandom));
      return;
    end
    if (kind != FR_GOOD && kind != FR_CUT_PAYLOAD) return;
    // a header rejected for capacity has no payload behind it
    body = (32'(HEADER_BYTES) + plen > 32'(cur_cap)) ? 0 : int'(plen);
    if (kind == FR_CUT_PAYLOAD && body != 0) body = $urandom_range(body - 1);
    repeat (body) send_word(CMD_DATA, 8'($urandom));
    if (kind == FR_CUT_PAYLOAD) send_word(CMD_FLUSH, 8'($urandom));
  endtask

  task automatic send_random_traffic();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) send_frame(FR_GOOD, -1);
    else if (pick < 66) send_frame(FR_BAD_MAGIC, -1);
    else if (pick < 72) send_frame(FR_BAD_VERSION, -1);
    else if (pick < 77) send_frame(FR_BAD_LENGTH, -1);
    else if (pick < 82) send_frame(FR_OVER_CAP, -1);
    else if (pick < 88) send_frame(FR_CUT_HEADER, -1);
    else if (pick < 94) send_frame(FR_CUT_PAYLOAD, -1);
    else begin
      // stray words, then a flush to realign on a frame boundary
      repeat ($urandom_range(6, 1))
        send_word(($urandom_range(9) == 0) ? CMD_FLUSH : CMD_DATA, 8'($urandom));
      send_word(CMD_FLUSH, 8'($urandom));
    end
  endtask

  initial begin : stimulus
    int phase;
    int target;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_command  = CMD_DATA;
    in_byte     = 8'h00;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_MAGIC;
    cfg_data    = 32'h0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    items_sent  = 0;
    cur_magic   = 32'h0;
    cur_version = 16'h0;
    cur_cap     = MAX_FRAME_BYTES;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, with the reset settings
    send_word(CMD_FLUSH, 8'hFF);
    send_frame(FR_GOOD, 0);
    send_frame(FR_CUT_HEADER, -1);
    send_frame(FR_BAD_LENGTH, int'(MAX_PLEN) + 1);
    // hold the output while a frame keeps coming so the block backs up
    hold_req = 1'b1;
    send_frame(FR_GOOD, 20);
    drain();

    apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'(HEADER_BYTES), 1'b1);
    send_frame(FR_GOOD, 0);
    // longest legal payload, turned away only by the capacity
    send_frame(FR_OVER_CAP, int'(MAX_PLEN));
    drain();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: apply_settings($urandom, $urandom, 32'(MAX_FRAME_BYTES), 1'b0);
        // capacity below the header size, upper data bits set
        default: apply_settings($urandom, $urandom, 32'hFFFF_E01F, 1'b1);
      endcase
      calm   = (phase == 0);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) send_random_traffic();
      drain();
    end
    calm = 1'b0;

    if (fail_count == 0 && pending_words == 0)
      $display("** magic_length_frame_deframer: PASSED **");
    else
      $display("** magic_length_frame_deframer: FAILED **");
    $finish;
  end

endmodule
